// ===== hw/rtl/cap_pkg.sv =====
// ----------------------------------------------------------------------------
// cap_pkg
// Shared types, widths and codes for the call auction price block.
// ----------------------------------------------------------------------------
package cap_pkg;

  // Table size and derived widths.
  localparam int MAX_ORDERS = 4096;
  localparam int IDX_W      = $clog2(MAX_ORDERS);
  localparam int CNT_W      = $clog2(MAX_ORDERS + 1);

  // Field widths.
  localparam int PRICE_W = 20;
  localparam int QTY_W   = 27;
  localparam int ID_W    = 13;
  localparam int VOL_W   = 39;
  localparam int SUM_W   = QTY_W + IDX_W;
  localparam int ORD_W   = 1 + PRICE_W + QTY_W;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    FUNC_BUY     = 2'd0,
    FUNC_SELL    = 2'd1,
    FUNC_CANCEL  = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_t;

  // Status codes of a result transaction.
  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2,
    ST_AUCTION  = 2'd3
  } status_t;

  // Input payload.
  typedef struct packed {
    func_t              func;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [ID_W-1:0]    cancel_id;
  } in_data_t;

  // Result payload.
  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    order_id;
    logic [PRICE_W-1:0] best_price;
    logic [VOL_W-1:0]   best_volume;
  } out_data_t;

  // One table entry in the order memory.
  typedef struct packed {
    logic               is_buy;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } order_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CANCEL_CHK,
    S_CAND_RD,
    S_CAND_CHK,
    S_SCAN,
    S_MIN,
    S_UPD,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic do_order;
    logic cancel_rd;
    logic cancel_fin;
    logic comp_start;
    logic cand_rd;
    logic cand_load;
    logic cand_next;
    logic scan_rd;
    logic min_take;
    logic best_upd;
    logic comp_fin;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  cand_done;
    logic  cand_live;
    logic  scan_done;
  } dp_status_t;

endpackage

// ===== hw/rtl/cap_ram.sv =====
// ----------------------------------------------------------------------------
// cap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/cap_ctrl.sv =====
// ----------------------------------------------------------------------------
// cap_ctrl
// Controller state machine: sequences orders, cancels and the auction scan.
// ----------------------------------------------------------------------------
module cap_ctrl import cap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t stat,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   res_load;

  // The result register may be refilled when empty or being emptied.
  assign slot_free = !out_valid || out_ready;
  assign res_load  = cmd.do_order || cmd.cancel_fin || cmd.comp_fin;

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.func)
          FUNC_BUY, FUNC_SELL: begin
            if (slot_free) begin
              cmd.do_order = 1'b1;
              state_next   = S_IDLE;
            end
          end
          FUNC_CANCEL: begin
            cmd.cancel_rd = 1'b1;
            state_next    = S_CANCEL_CHK;
          end
          default: begin
            cmd.comp_start = 1'b1;
            state_next     = S_CAND_RD;
          end
        endcase
      end
      S_CANCEL_CHK: begin
        if (slot_free) begin
          cmd.cancel_fin = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_CAND_RD: begin
        if (stat.cand_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.cand_rd = 1'b1;
          state_next  = S_CAND_CHK;
        end
      end
      S_CAND_CHK: begin
        if (stat.cand_live) begin
          cmd.cand_load = 1'b1;
          state_next    = S_SCAN;
        end else begin
          cmd.cand_next = 1'b1;
          state_next    = S_CAND_RD;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_MIN;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_MIN: begin
        cmd.min_take = 1'b1;
        state_next   = S_UPD;
      end
      S_UPD: begin
        cmd.best_upd  = 1'b1;
        cmd.cand_next = 1'b1;
        state_next    = S_CAND_RD;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.comp_fin = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cap_datapath.sv =====
// ----------------------------------------------------------------------------
// cap_datapath
// Order table memories, id counter, volume accumulators and result register.
// ----------------------------------------------------------------------------
module cap_datapath import cap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  in_data_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t stat,
  output out_data_t  out_data
);

  // Captured transaction.
  in_data_t           item;

  // Number of ids handed out; entries below it have been written.
  logic [CNT_W-1:0]   cnt;
  logic               full;

  // Scan counters and accumulators.
  logic [CNT_W-1:0]   cand_idx;
  logic [CNT_W-1:0]   scan_idx;
  logic               acc_v;
  logic [PRICE_W-1:0] cand;
  logic [SUM_W-1:0]   buy_sum;
  logic [SUM_W-1:0]   sell_sum;
  logic [SUM_W-1:0]   matched;
  logic [PRICE_W-1:0] best_p;
  logic [SUM_W-1:0]   best_v;

  // Memory ports.
  logic               ord_we;
  order_t             ord_wdata;
  logic               ord_re;
  logic [IDX_W-1:0]   ord_raddr;
  order_t             ord_rdata;
  logic               live_we;
  logic [IDX_W-1:0]   live_waddr;
  logic               live_wdata;
  logic               live_re;
  logic [IDX_W-1:0]   live_raddr;
  logic               live_rdata;
  logic [IDX_W-1:0]   cancel_idx;
  logic               cancel_ok;

  assign full       = (cnt == CNT_W'(MAX_ORDERS));
  assign cancel_idx = IDX_W'(32'(item.cancel_id) - 32'd1);
  assign cancel_ok  = (item.cancel_id != '0) &&
                      (32'(item.cancel_id) <= 32'(cnt)) && live_rdata;

  // Memory port selection.
  always_comb begin
    ord_we            = cmd.do_order && !full;
    ord_wdata.is_buy  = (item.func == FUNC_BUY);
    ord_wdata.price   = item.price;
    ord_wdata.quantity = item.quantity;
    ord_re            = cmd.cand_rd || cmd.scan_rd;
    ord_raddr         = cmd.cand_rd ? cand_idx[IDX_W-1:0] : scan_idx[IDX_W-1:0];
    live_we           = (cmd.do_order && !full) || (cmd.cancel_fin && cancel_ok);
    live_wdata        = cmd.do_order;
    live_waddr        = cmd.do_order ? cnt[IDX_W-1:0] : cancel_idx;
    live_re           = cmd.cand_rd || cmd.scan_rd || cmd.cancel_rd;
    if (cmd.cancel_rd) begin
      live_raddr = cancel_idx;
    end else begin
      live_raddr = ord_raddr;
    end
  end

  cap_ram #(
    .WIDTH (ORD_W),
    .DEPTH (MAX_ORDERS)
  ) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (ord_wdata),
    .re    (ord_re),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  cap_ram #(
    .WIDTH (1),
    .DEPTH (MAX_ORDERS)
  ) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .re    (live_re),
    .raddr (live_raddr),
    .rdata (live_rdata)
  );

  // Control registers: id counter and scan read pipeline flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      acc_v <= 1'b0;
    end else begin
      acc_v <= cmd.scan_rd;
      if (cmd.do_order && !full) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
  end

  // Candidate and scan counters.
  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      cand_idx <= '0;
    end else if (cmd.cand_next) begin
      cand_idx <= cand_idx + CNT_W'(1);
    end
    if (cmd.cand_load) begin
      scan_idx <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
  end

  // Volume accumulation over the table for the current candidate price.
  always_ff @(posedge clk) begin
    if (cmd.cand_load) begin
      cand     <= ord_rdata.price;
      buy_sum  <= '0;
      sell_sum <= '0;
    end else if (acc_v && live_rdata) begin
      if (ord_rdata.is_buy) begin
        if (cand <= ord_rdata.price) begin
          buy_sum <= buy_sum + SUM_W'(ord_rdata.quantity);
        end
      end else begin
        if (cand >= ord_rdata.price) begin
          sell_sum <= sell_sum + SUM_W'(ord_rdata.quantity);
        end
      end
    end
  end

  // Matched volume and best candidate, ties going to the higher price.
  always_ff @(posedge clk) begin
    if (cmd.min_take) begin
      matched <= (buy_sum < sell_sum) ? buy_sum : sell_sum;
    end
    if (cmd.comp_start) begin
      best_p <= '0;
      best_v <= '0;
    end else if (cmd.best_upd) begin
      if ((matched > best_v) || ((matched == best_v) && (cand > best_p))) begin
        best_p <= cand;
        best_v <= matched;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.do_order) begin
      out_data.best_price  <= '0;
      out_data.best_volume <= '0;
      if (full) begin
        out_data.status   <= ST_FULL;
        out_data.order_id <= '0;
      end else begin
        out_data.status   <= ST_ACCEPTED;
        out_data.order_id <= ID_W'(cnt + CNT_W'(1));
      end
    end else if (cmd.cancel_fin) begin
      out_data.status      <= cancel_ok ? ST_ACCEPTED : ST_NOT_LIVE;
      out_data.order_id    <= '0;
      out_data.best_price  <= '0;
      out_data.best_volume <= '0;
    end else if (cmd.comp_fin) begin
      out_data.status      <= ST_AUCTION;
      out_data.order_id    <= '0;
      out_data.best_price  <= best_p;
      out_data.best_volume <= VOL_W'(best_v);
    end
  end

  // Status to the controller.
  assign stat.func      = item.func;
  assign stat.cand_done = (cand_idx == cnt);
  assign stat.cand_live = live_rdata;
  assign stat.scan_done = (scan_idx == cnt);

endmodule

// ===== hw/rtl/call_auction_price.sv =====
// ----------------------------------------------------------------------------
// call_auction_price
// Order table with cancel and a call auction opening price search.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                        Payload
//   -------   ----------------------------   ----------------------------------
//   input     in_valid, in_ready, in_data    func, price, quantity, cancel_id
//   output    out_valid, out_ready, out_data status, order_id, best_price,
//                                            best_volume
//
// One transaction is in work at a time. A buy or sell is captured, then
// written to the table; a cancel is captured, reads the live flags with a
// registered read, then clears the flag of a live order. A compute reads
// each of the N ids handed out as a candidate, and each live candidate
// sweeps all N table entries at one entry a cycle.
// Reset is synchronous; the table needs no clearing pass, since entries at
// or above the id count are never used. A stalled result holds the next
// finished result back, while one new transaction is still taken in.
//
module call_auction_price import cap_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_data_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  cap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cap_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/cap_checker.sv =====
// ----------------------------------------------------------------------------
// cap_checker
// Port-level checks for the call auction price block, bound to the top level.
// ----------------------------------------------------------------------------
module cap_checker import cap_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_data_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_data_t out_data
);

  // A waiting input transaction stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transaction changed while waiting");

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Only one transaction is in work, so the input closes after a transaction.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in work");

  // Only an accepted order carries an id.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_ACCEPTED) |-> (out_data.order_id == '0))
    else $error("order id on a result that is not an accepted order");

  // Price and volume are zero on everything but an auction result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_AUCTION) |->
      (out_data.best_price == '0) && (out_data.best_volume == '0))
    else $error("auction fields set on a non-auction result");

endmodule

bind call_auction_price cap_checker u_cap_checker (.*);

// ===== tb/tb_call_auction_price.sv =====
// ----------------------------------------------------------------------------
// tb_call_auction_price
// Self-checking bench for the call auction price block. A behavioral model
// of the order book predicts every result transaction. The stimulus covers
// order entry, cancels with good and bad ids, and auction runs at small table
// occupancy, with a long result stall part way through.
// ----------------------------------------------------------------------------
module tb_call_auction_price;
  timeunit 1ns;
  timeprecision 1ps;
  import cap_pkg::*;

  localparam int          PRICE_MAX    = 1000000;
  localparam int          QTY_MAX      = 2**QTY_W - 1;
  localparam int          ID_SPACE     = 2**ID_W - 1;
  localparam int          RAND_ITEMS   = 1360;
  localparam int          HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 8000000;

  // Behavioral order book: holds the table and the queue of expected results.
  class auction_book;
    logic [PRICE_W-1:0] price_tab [MAX_ORDERS];
    logic [QTY_W-1:0]   qty_tab   [MAX_ORDERS];
    bit                 buy_tab   [MAX_ORDERS];
    bit                 live_tab  [MAX_ORDERS];
    int                 next_id;
    out_data_t          pending_results [$];
    int                 mismatches;
    int                 checked;

    function new();
      next_id    = 1;
      mismatches = 0;
      checked    = 0;
      foreach (live_tab[i]) live_tab[i] = 1'b0;
    endfunction

    // Try every live price; keep the best matched volume, higher price on ties.
    function void opening_price(output logic [PRICE_W-1:0] bp, output logic [VOL_W-1:0] bv);
      int                 slots [$];
      longint unsigned    buys, sells, matched, top_vol;
      logic [PRICE_W-1:0] cand, top_price;
      top_vol   = 0;
      top_price = '0;
      for (int i = 0; i < next_id - 1; i++) begin
        if (live_tab[i]) slots = {slots, i};
      end
      foreach (slots[c]) begin
        cand  = price_tab[slots[c]];
        buys  = 0;
        sells = 0;
        foreach (slots[k]) begin
          if (buy_tab[slots[k]]) begin
            if (cand <= price_tab[slots[k]]) buys += qty_tab[slots[k]];
          end else if (cand >= price_tab[slots[k]]) begin
            sells += qty_tab[slots[k]];
          end
        end
        matched = (buys < sells) ? buys : sells;
        if (matched > top_vol || (matched == top_vol && cand > top_price)) begin
          top_vol   = matched;
          top_price = cand;
        end
      end
      bp = top_price;
      bv = top_vol[VOL_W-1:0];
    endfunction

    // Apply one accepted input transaction and queue its expected result.
    function void take_item(in_data_t d);
      out_data_t          e;
      int                 slot;
      logic [PRICE_W-1:0] bp;
      logic [VOL_W-1:0]   bv;
      e = '0;
      case (d.func)
        FUNC_BUY, FUNC_SELL: begin
          if (next_id > MAX_ORDERS) begin
            e.status = ST_FULL;
          end else begin
            slot           = next_id - 1;
            price_tab[slot] = d.price;
            qty_tab[slot]   = d.quantity;
            buy_tab[slot]   = (d.func == FUNC_BUY);
            live_tab[slot]  = 1'b1;
            e.status        = ST_ACCEPTED;
            e.order_id      = ID_W'(next_id);
            next_id++;
          end
        end
        FUNC_CANCEL: begin
          slot = int'(d.cancel_id) - 1;
          if (d.cancel_id >= 1 && d.cancel_id <= MAX_ORDERS && live_tab[slot]) begin
            live_tab[slot] = 1'b0;
            e.status       = ST_ACCEPTED;
          end else begin
            e.status = ST_NOT_LIVE;
          end
        end
        default: begin
          opening_price(bp, bv);
          e.status      = ST_AUCTION;
          e.best_price  = bp;
          e.best_volume = bv;
        end
      endcase
      pending_results = {pending_results, e};
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(out_data_t got);
      out_data_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, status %0d id %0d price %0d volume %0d",
                 $time, got.status, got.order_id, got.best_price, got.best_volume);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("status", want.status, got.status);
      compare_field("order_id", want.order_id, got.order_id);
      compare_field("best_price", want.best_price, got.best_price);
      compare_field("best_volume", want.best_volume, got.best_volume);
    endfunction
  endclass

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_data_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_data_t out_data;

  auction_book book;
  bit          idle_on  = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;

  // Stimulus-side view of the ids, kept in the order transactions are issued.
  int gen_next_id = 1;
  int gen_live [$];
  int gen_gone [$];
  int band_base   = 0;
  int n_items     = 0;
  int n_auctions  = 0;

  call_auction_price i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_data_t item(func_t f, int p, int q, int c);
    in_data_t d;
    d.func      = f;
    d.price     = PRICE_W'(p);
    d.quantity  = QTY_W'(q);
    d.cancel_id = ID_W'(c);
    return d;
  endfunction

  // Half of the prices fall in a narrow band so that buys and sells overlap.
  function automatic int pick_price();
    case ($urandom_range(0, 9))
      0:             return 0;
      1:             return PRICE_MAX;
      2, 3, 4, 5, 6: return band_base + $urandom_range(0, 40);
      default:       return $urandom_range(0, PRICE_MAX);
    endcase
  endfunction

  function automatic int pick_qty();
    case ($urandom_range(0, 9))
      0:          return 0;
      1:          return QTY_MAX;
      2, 3, 4:    return $urandom_range(1, 100);
      default:    return $urandom_range(0, QTY_MAX);
    endcase
  endfunction

  function automatic in_data_t order_item(func_t f);
    return item(f, pick_price(), pick_qty(), $urandom_range(0, ID_SPACE));
  endfunction

  function automatic in_data_t cancel_item(int id);
    return item(FUNC_CANCEL, $urandom_range(0, PRICE_MAX), $urandom_range(0, QTY_MAX), id);
  endfunction

  function automatic in_data_t compute_item();
    return item(FUNC_COMPUTE, $urandom_range(0, PRICE_MAX), $urandom_range(0, QTY_MAX),
                $urandom_range(0, ID_SPACE));
  endfunction

  function automatic int live_id();
    return gen_live[$urandom_range(0, gen_live.size() - 1)];
  endfunction

  // Ids for refused cancels: zero, cancelled, never issued, out of range, or a random id that may be live.
  function automatic int bad_id();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return (gen_gone.size() != 0) ? gen_gone[$urandom_range(0, gen_gone.size() - 1)] : 0;
      2:       return gen_next_id;
      3:       return $urandom_range(MAX_ORDERS + 1, ID_SPACE);
      default: return $urandom_range(0, ID_SPACE);
    endcase
  endfunction

  // Drive one input transaction and wait until the block takes it.
  task automatic send_item(in_data_t d);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    book.take_item(d);
  endtask

  // Track id usage on the stimulus side, then send.
  task automatic issue(in_data_t d);
    int pos [$];
    case (d.func)
      FUNC_BUY, FUNC_SELL: begin
        if (gen_next_id <= MAX_ORDERS) begin
          gen_live = {gen_live, gen_next_id};
          gen_next_id++;
        end
      end
      FUNC_CANCEL: begin
        pos = gen_live.find_first_index(x) with (x == int'(d.cancel_id));
        if (pos.size() != 0) begin
          gen_live.delete(pos[0]);
          gen_gone = {gen_gone, int'(d.cancel_id)};
        end
      end
      default: n_auctions++;
    endcase
    n_items++;
    send_item(d);
  endtask

  // One random transaction; the live count is kept from growing past the cap to bound
  // the auction search time.
  task automatic random_item(int cap);
    int r;
    r = $urandom_range(0, 99);
    if (gen_live.size() >= cap) begin
      issue(cancel_item(live_id()));
    end else if (r < 8) begin
      issue(compute_item());
    end else if (r < 55) begin
      issue(order_item((r < 31) ? FUNC_BUY : FUNC_SELL));
    end else if (r < 85 && gen_live.size() != 0) begin
      issue(cancel_item(live_id()));
    end else begin
      issue(cancel_item(bad_id()));
    end
  endtask

  // Result side: check accepted results and vary out_ready.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) book.check_result(out_data);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    book = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed transactions: empty table, extreme fields, bad cancels, ties.
    issue(item(FUNC_COMPUTE, 0, 0, 0));
    issue(item(FUNC_CANCEL, 0, 0, 0));
    issue(item(FUNC_BUY, PRICE_MAX, QTY_MAX, 0));
    issue(item(FUNC_SELL, 0, QTY_MAX, ID_SPACE));
    issue(item(FUNC_COMPUTE, 0, 0, 0));
    issue(item(FUNC_CANCEL, 0, 0, 1));
    issue(item(FUNC_CANCEL, PRICE_MAX, QTY_MAX, 1));
    issue(item(FUNC_COMPUTE, PRICE_MAX, QTY_MAX, ID_SPACE));
    issue(item(FUNC_BUY, 0, 0, 0));
    issue(item(FUNC_SELL, PRICE_MAX, 0, 0));
    issue(item(FUNC_COMPUTE, 0, 0, 0));
    issue(item(FUNC_CANCEL, 0, 0, ID_SPACE));
    issue(item(FUNC_CANCEL, 0, 0, MAX_ORDERS + 1));
    issue(item(FUNC_CANCEL, 0, 0, MAX_ORDERS));
    issue(item(FUNC_CANCEL, 0, 0, 7));
    issue(item(FUNC_CANCEL, 0, 0, 2));
    issue(item(FUNC_CANCEL, 0, 0, 3));
    issue(item(FUNC_CANCEL, 0, 0, 4));
    issue(item(FUNC_COMPUTE, 0, 0, 0));
    issue(item(FUNC_BUY, 200, 5, 0));
    issue(item(FUNC_SELL, 150, 5, 0));
    issue(item(FUNC_COMPUTE, 0, 0, 0));
    issue(item(FUNC_BUY, 100, 9, 0));
    issue(item(FUNC_SELL, 300, 4, 0));
    issue(item(FUNC_CANCEL, 0, 0, 5));
    issue(item(FUNC_CANCEL, 0, 0, 6));
    issue(item(FUNC_COMPUTE, 0, 0, 0));

    // Random traffic; the price band and idling change every hundred items,
    // and the last stretch runs without idling.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        band_base = $urandom_range(0, PRICE_MAX - 40);
        idle_on   = (n < RAND_ITEMS - 200) && ($urandom_range(0, 3) != 0);
      end
      if (n == 300) hold_req = 1'b1;
      random_item((gen_next_id < 200) ? 24 : 10);
    end

    // Closing transactions: ids at the top of the range, a cancel, auctions.
    idle_on = 1'b0;
    issue(order_item(FUNC_BUY));
    issue(order_item(FUNC_SELL));
    issue(compute_item());
    issue(cancel_item(MAX_ORDERS));
    issue(cancel_item(MAX_ORDERS + 1));
    if (gen_live.size() != 0) issue(cancel_item(live_id()));
    issue(compute_item());
    in_valid <= 1'b0;

    while (book.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d transactions including %0d auctions; %0d order ids were issued",
             n_items, n_auctions, gen_next_id - 1);
    $display("Checked %0d results, %0d mismatches", book.checked, book.mismatches);
    if (book.mismatches == 0 && book.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== call_auction_price.f =====
hw/rtl/cap_pkg.sv
hw/rtl/cap_ram.sv
hw/rtl/cap_ctrl.sv
hw/rtl/cap_datapath.sv
hw/rtl/call_auction_price.sv
hw/rtl/cap_checker.sv
tb/tb_call_auction_price.sv
